/* design/i2cmbe_pkg.sv */
// Shared types and constants for the I2C master bit engine.
// Used by the front, queue, back and top level modules; depends on nothing.
package i2cmbe_pkg;

  localparam int unsigned PHASE_W = 4;
  localparam int unsigned BIT_W = 3;
  localparam logic [7:0] HALF_PERIOD_RESET = 8'd10;
  localparam logic [BIT_W-1:0] LAST_BIT = 3'd7;

  typedef enum logic [2:0] {
    OP_IDLE  = 3'd0,
    OP_START = 3'd1,
    OP_STOP  = 3'd2,
    OP_WRITE = 3'd3,
    OP_READ  = 3'd4,
    OP_WAIT  = 3'd5,
    OP_ACK   = 3'd6,
    OP_NACK  = 3'd7
  } op_t;

  typedef struct packed {
    logic               is_tick;
    op_t                op;
    logic [PHASE_W-1:0] first_phase;
    logic               load_shift;
    logic [7:0]         shift_init;
    logic               load_choice;
    logic               choice_init;
    logic               sda_in;
  } entry_t;

  typedef struct packed {
    logic       scl_out;
    logic       sda_out;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_data;
    logic       ack_received;
    logic       rejected;
  } result_t;

endpackage

/* design/i2cmbe_front.sv */
// Front stage: accepts requests and classifies them into queue entries.
// Depends on i2cmbe_pkg.
module i2cmbe_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [2:0]          in_req_type,
  input  logic [7:0]          in_write_data,
  input  logic                in_ack_after_read,
  input  logic                in_sda_in,
  output logic                push,
  output i2cmbe_pkg::entry_t  push_entry,
  input  logic                queue_full
);

  logic               valid_r;
  logic               valid_nxt;
  i2cmbe_pkg::entry_t entry_r;
  i2cmbe_pkg::entry_t entry_nxt;
  logic               accept;

  assign in_stall = valid_r && queue_full;
  assign push = valid_r && !queue_full;
  assign accept = in_valid && !in_stall;
  assign push_entry = entry_r;

  always_comb begin
    i2cmbe_pkg::op_t op;
    op = i2cmbe_pkg::op_t'(in_req_type);
    entry_nxt.op = op;
    entry_nxt.is_tick = (op == i2cmbe_pkg::OP_IDLE);
    entry_nxt.sda_in = in_sda_in;
    entry_nxt.first_phase = (op == i2cmbe_pkg::OP_ACK || op == i2cmbe_pkg::OP_NACK) ?
                            i2cmbe_pkg::PHASE_W'(3) : '0;
    entry_nxt.load_shift = (op == i2cmbe_pkg::OP_WRITE || op == i2cmbe_pkg::OP_READ);
    entry_nxt.shift_init = (op == i2cmbe_pkg::OP_WRITE) ? in_write_data : 8'd0;
    entry_nxt.load_choice = (op == i2cmbe_pkg::OP_READ || op == i2cmbe_pkg::OP_ACK ||
                             op == i2cmbe_pkg::OP_NACK);
    entry_nxt.choice_init = (op == i2cmbe_pkg::OP_READ) ? in_ack_after_read :
                            (op == i2cmbe_pkg::OP_ACK);
  end

  always_comb begin
    valid_nxt = valid_r;
    if (accept) begin
      valid_nxt = 1'b1;
    end else if (push) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      entry_r <= entry_nxt;
    end
  end

endmodule

/* design/i2cmbe_fifo.sv */
// Short queue of classified entries between the front and back stages.
// Depends on i2cmbe_pkg.
module i2cmbe_fifo #(
  parameter int unsigned DEPTH = 2
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  i2cmbe_pkg::entry_t push_entry,
  output logic               full,
  input  logic               pop,
  output logic               not_empty,
  output i2cmbe_pkg::entry_t pop_entry
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

  i2cmbe_pkg::entry_t slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign full = (count_r == CNT_W'(DEPTH));
  assign not_empty = (count_r != '0);
  assign pop_entry = slots[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr_r] <= push_entry;
    end
  end

endmodule

/* design/i2cmbe_back.sv */
// Back stage: bus phase sequencer, half period register and result register.
// Depends on i2cmbe_pkg.
module i2cmbe_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_write,
  input  logic [7:0]         cfg_data,
  input  logic               entry_valid,
  input  i2cmbe_pkg::entry_t entry,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_stall,
  output i2cmbe_pkg::result_t result
);

  localparam logic [i2cmbe_pkg::PHASE_W-1:0] PH0 = i2cmbe_pkg::PHASE_W'(0);
  localparam logic [i2cmbe_pkg::PHASE_W-1:0] PH1 = i2cmbe_pkg::PHASE_W'(1);
  localparam logic [i2cmbe_pkg::PHASE_W-1:0] PH2 = i2cmbe_pkg::PHASE_W'(2);
  localparam logic [i2cmbe_pkg::PHASE_W-1:0] PH3 = i2cmbe_pkg::PHASE_W'(3);
  localparam logic [i2cmbe_pkg::PHASE_W-1:0] PH4 = i2cmbe_pkg::PHASE_W'(4);
  localparam logic [i2cmbe_pkg::PHASE_W-1:0] PH5 = i2cmbe_pkg::PHASE_W'(5);

  logic [7:0]                     half_period_r;
  i2cmbe_pkg::op_t                op_r, op_nxt;
  logic [i2cmbe_pkg::PHASE_W-1:0] phase_r, phase_nxt;
  logic [i2cmbe_pkg::BIT_W-1:0]   bit_r, bit_nxt;
  logic [7:0]                     shift_r, shift_nxt;
  logic [7:0]                     delay_r, delay_nxt;
  logic                           scl_r, scl_nxt;
  logic                           sda_r, sda_nxt;
  logic                           ack_r, ack_nxt;
  logic                           choice_r, choice_nxt;
  logic [7:0]                     last_read_r, last_read_nxt;
  logic                           done_nxt;
  logic                           rej_nxt;
  logic                           out_valid_r, out_valid_nxt;
  i2cmbe_pkg::result_t            result_r, result_nxt;

  assign pop = entry_valid && (!out_valid_r || !out_stall);
  assign out_valid = out_valid_r;
  assign result = result_r;

  always_comb begin
    logic                           run;
    logic                           fin;
    logic [i2cmbe_pkg::PHASE_W-1:0] p;
    logic [7:0]                     dly;
    run = 1'b0;
    fin = 1'b0;
    p = phase_r + 1'b1;
    dly = '0;
    op_nxt = op_r;
    phase_nxt = phase_r;
    bit_nxt = bit_r;
    shift_nxt = shift_r;
    delay_nxt = delay_r;
    scl_nxt = scl_r;
    sda_nxt = sda_r;
    ack_nxt = ack_r;
    choice_nxt = choice_r;
    last_read_nxt = last_read_r;
    done_nxt = 1'b0;
    rej_nxt = 1'b0;

    if (entry.is_tick) begin
      if (op_r != i2cmbe_pkg::OP_IDLE) begin
        dly = (delay_r != 8'd0) ? delay_r - 8'd1 : 8'd0;
        delay_nxt = dly;
        run = (dly == 8'd0);
      end
    end else if (op_r != i2cmbe_pkg::OP_IDLE) begin
      rej_nxt = 1'b1;
    end else begin
      op_nxt = entry.op;
      bit_nxt = '0;
      if (entry.load_shift) begin
        shift_nxt = entry.shift_init;
      end
      if (entry.load_choice) begin
        choice_nxt = entry.choice_init;
      end
      p = entry.first_phase;
      run = 1'b1;
    end

    if (run) begin
      phase_nxt = p;
      case (op_nxt)
        i2cmbe_pkg::OP_START: begin
          case (p)
            PH0: begin
              sda_nxt = 1'b1;
              scl_nxt = 1'b1;
            end
            PH1: sda_nxt = 1'b0;
            PH2: scl_nxt = 1'b0;
            default: fin = 1'b1;
          endcase
        end
        i2cmbe_pkg::OP_STOP: begin
          if (p == PH0) begin
            sda_nxt = 1'b0;
            scl_nxt = 1'b1;
          end else begin
            sda_nxt = 1'b1;
            fin = 1'b1;
          end
        end
        i2cmbe_pkg::OP_WRITE: begin
          case (p)
            PH0: sda_nxt = shift_nxt[7];
            PH1: scl_nxt = 1'b1;
            PH2: begin
              scl_nxt = 1'b0;
              if (bit_nxt == i2cmbe_pkg::LAST_BIT) begin
                sda_nxt = 1'b1;
              end
              shift_nxt = {shift_nxt[6:0], 1'b0};
            end
            default: begin
              if (bit_nxt == i2cmbe_pkg::LAST_BIT) begin
                fin = 1'b1;
              end else begin
                bit_nxt = bit_nxt + 1'b1;
                phase_nxt = PH0;
                sda_nxt = shift_nxt[7];
              end
            end
          endcase
        end
        i2cmbe_pkg::OP_WAIT: begin
          case (p)
            PH0: sda_nxt = 1'b1;
            PH1: scl_nxt = 1'b1;
            PH2: begin
              ack_nxt = entry.sda_in;
              scl_nxt = 1'b0;
            end
            default: fin = 1'b1;
          endcase
        end
        i2cmbe_pkg::OP_READ, i2cmbe_pkg::OP_ACK, i2cmbe_pkg::OP_NACK: begin
          case (p)
            PH0: scl_nxt = 1'b1;
            PH1: begin
              shift_nxt = {shift_nxt[6:0], entry.sda_in};
              scl_nxt = 1'b0;
            end
            PH2: begin
              if (bit_nxt != i2cmbe_pkg::LAST_BIT) begin
                bit_nxt = bit_nxt + 1'b1;
                phase_nxt = PH0;
                scl_nxt = 1'b1;
              end else begin
                phase_nxt = PH3;
                sda_nxt = !choice_nxt;
              end
            end
            PH3: sda_nxt = !choice_nxt;
            PH4: scl_nxt = 1'b1;
            PH5: scl_nxt = 1'b0;
            default: begin
              sda_nxt = 1'b1;
              if (op_nxt == i2cmbe_pkg::OP_READ) begin
                last_read_nxt = shift_nxt;
              end
              fin = 1'b1;
            end
          endcase
        end
        default: fin = 1'b1;
      endcase

      if (fin) begin
        op_nxt = i2cmbe_pkg::OP_IDLE;
        phase_nxt = PH0;
        delay_nxt = 8'd0;
        done_nxt = entry.is_tick;
      end else begin
        delay_nxt = (half_period_r == 8'd0) ? 8'd1 : half_period_r;
      end
    end
  end

  always_comb begin
    result_nxt.scl_out = scl_nxt;
    result_nxt.sda_out = sda_nxt;
    result_nxt.busy_res = (op_nxt != i2cmbe_pkg::OP_IDLE);
    result_nxt.done_res = done_nxt;
    result_nxt.read_data = last_read_nxt;
    result_nxt.ack_received = ack_nxt;
    result_nxt.rejected = rej_nxt;
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (pop) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_period_r <= i2cmbe_pkg::HALF_PERIOD_RESET;
    end else if (cfg_write) begin
      half_period_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      op_r <= i2cmbe_pkg::OP_IDLE;
      phase_r <= '0;
      bit_r <= '0;
      shift_r <= '0;
      delay_r <= '0;
      scl_r <= 1'b1;
      sda_r <= 1'b1;
      ack_r <= 1'b0;
      choice_r <= 1'b0;
      last_read_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (pop) begin
        op_r <= op_nxt;
        phase_r <= phase_nxt;
        bit_r <= bit_nxt;
        shift_r <= shift_nxt;
        delay_r <= delay_nxt;
        scl_r <= scl_nxt;
        sda_r <= sda_nxt;
        ack_r <= ack_nxt;
        choice_r <= choice_nxt;
        last_read_r <= last_read_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      result_r <= result_nxt;
    end
  end

endmodule

/* design/i2c_master_bit_engine_core.sv */
// Top level of the I2C master bit engine: front stage, queue and back stage.
// Depends on i2cmbe_pkg, i2cmbe_front, i2cmbe_fifo and i2cmbe_back.
//
//   Channel   Handshake            Payload
//   in_       in_valid / in_stall  req_type, write_data, ack_after_read, sda_in
//   out_      out_valid / out_stall scl_out, sda_out, busy_res, done_res,
//                                  read_data, ack_received, rejected
//   cfg_      cfg_valid / cfg_ready half_period write data
//
// One request per cycle is sustained while out_stall stays low; every request, tick or
// command, yields one result. A request is registered in the front register, then in a
// queue slot, and the phase step then loads its result into the result register, from
// which the result is offered.
// Reset restores half_period to 10, idles the sequencer and releases SCL and SDA.
// in_stall rises only when the front register and the queue are both full.
module i2c_master_bit_engine_core #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [2:0] in_req_type,
  input  logic [7:0] in_write_data,
  input  logic       in_ack_after_read,
  input  logic       in_sda_in,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_scl_out,
  output logic       out_sda_out,
  output logic       out_busy_res,
  output logic       out_done_res,
  output logic [7:0] out_read_data,
  output logic       out_ack_received,
  output logic       out_rejected,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_data
);

  logic                push;
  i2cmbe_pkg::entry_t  push_entry;
  logic                queue_full;
  logic                pop;
  logic                queue_not_empty;
  i2cmbe_pkg::entry_t  pop_entry;
  i2cmbe_pkg::result_t result;

  assign cfg_ready = 1'b1;

  i2cmbe_front u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_req_type       (in_req_type),
    .in_write_data     (in_write_data),
    .in_ack_after_read (in_ack_after_read),
    .in_sda_in         (in_sda_in),
    .push              (push),
    .push_entry        (push_entry),
    .queue_full        (queue_full)
  );

  i2cmbe_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .full       (queue_full),
    .pop        (pop),
    .not_empty  (queue_not_empty),
    .pop_entry  (pop_entry)
  );

  i2cmbe_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_write   (cfg_valid && cfg_ready),
    .cfg_data    (cfg_data),
    .entry_valid (queue_not_empty),
    .entry       (pop_entry),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .result      (result)
  );

  assign out_scl_out = result.scl_out;
  assign out_sda_out = result.sda_out;
  assign out_busy_res = result.busy_res;
  assign out_done_res = result.done_res;
  assign out_read_data = result.read_data;
  assign out_ack_received = result.ack_received;
  assign out_rejected = result.rejected;

endmodule

/* tb/sv/i2c_bus_checker.sv */
// Result checker for the I2C master bit engine core: it predicts the bus levels for every
// accepted request and compares each accepted result against them, field by field.
// Depends on i2cmbe_pkg only.
module i2c_bus_checker
  import i2cmbe_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic [2:0] in_req_type,
  input  logic [7:0] in_write_data,
  input  logic       in_ack_after_read,
  input  logic       in_sda_in,
  input  logic       out_valid,
  input  logic       out_stall,
  input  logic       out_scl_out,
  input  logic       out_sda_out,
  input  logic       out_busy_res,
  input  logic       out_done_res,
  input  logic [7:0] out_read_data,
  input  logic       out_ack_received,
  input  logic       out_rejected,
  input  logic       cfg_valid,
  input  logic       cfg_ready,
  input  logic [7:0] cfg_data,
  output int         error_count,
  output int         open_count
);
  timeunit 1ns;
  timeprecision 1ps;

  op_t                busy_op;
  logic [PHASE_W-1:0] step_ph;
  logic [BIT_W-1:0]   bit_pos;
  logic [7:0]         shifter;
  logic [7:0]         wait_left;
  logic [7:0]         half_period;
  logic [7:0]         last_read;
  logic               scl_lv;
  logic               sda_lv;
  logic               ack_lv;
  logic               ack_choice;
  result_t            bus_results_due[$];

  task automatic enter_step(input int unsigned p, input logic sin, output logic ended);
    logic settled;
    settled = 1'b0;
    ended = 1'b0;
    while (!settled) begin
      step_ph = p[PHASE_W-1:0];
      settled = 1'b1;
      case (busy_op)
        OP_START: begin
          if (p == 0) begin
            sda_lv = 1'b1;
            scl_lv = 1'b1;
          end else if (p == 1) sda_lv = 1'b0;
          else if (p == 2) scl_lv = 1'b0;
          else ended = 1'b1;
        end
        OP_STOP: begin
          if (p == 0) begin
            sda_lv = 1'b0;
            scl_lv = 1'b1;
          end else begin
            sda_lv = 1'b1;
            ended = 1'b1;
          end
        end
        OP_WRITE: begin
          if (p == 0) sda_lv = shifter[7];
          else if (p == 1) scl_lv = 1'b1;
          else if (p == 2) begin
            scl_lv = 1'b0;
            if (bit_pos == LAST_BIT) sda_lv = 1'b1;
            shifter = shifter << 1;
          end else if (bit_pos == LAST_BIT) ended = 1'b1;
          else begin
            bit_pos++;
            p = 0;
            settled = 1'b0;
          end
        end
        OP_WAIT: begin
          if (p == 0) sda_lv = 1'b1;
          else if (p == 1) scl_lv = 1'b1;
          else if (p == 2) begin
            ack_lv = sin;
            scl_lv = 1'b0;
          end else ended = 1'b1;
        end
        default: begin
          // Read byte, send ACK and send NACK share the same clocking sequence.
          if (p == 0) scl_lv = 1'b1;
          else if (p == 1) begin
            shifter = {shifter[6:0], sin};
            scl_lv = 1'b0;
          end else if (p == 2) begin
            if (bit_pos != LAST_BIT) begin
              bit_pos++;
              p = 0;
            end else begin
              p = 3;
            end
            settled = 1'b0;
          end else if (p == 3) sda_lv = !ack_choice;
          else if (p == 4) scl_lv = 1'b1;
          else if (p == 5) scl_lv = 1'b0;
          else begin
            sda_lv = 1'b1;
            if (busy_op == OP_READ) last_read = shifter;
            ended = 1'b1;
          end
        end
      endcase
    end
    if (ended) begin
      busy_op = OP_IDLE;
      step_ph = '0;
      wait_left = '0;
    end else begin
      wait_left = (half_period == 8'd0) ? 8'd1 : half_period;
    end
  endtask

  task automatic predict_bus_step(input logic [2:0] rq, input logic [7:0] wd, input logic ar,
                                  input logic sin);
    result_t levels;
    logic    ended;
    logic    done;
    logic    rej;
    done = 1'b0;
    rej = 1'b0;
    ended = 1'b0;
    if (rq == OP_IDLE) begin
      if (busy_op != OP_IDLE) begin
        if (wait_left > 0) wait_left--;
        if (wait_left == 0) begin
          enter_step(step_ph + 1, sin, ended);
          done = ended;
        end
      end
    end else if (busy_op != OP_IDLE) begin
      rej = 1'b1;
    end else begin
      busy_op = op_t'(rq);
      bit_pos = '0;
      case (busy_op)
        OP_WRITE: begin
          shifter = wd;
          enter_step(0, 1'b0, ended);
        end
        OP_READ: begin
          shifter = '0;
          ack_choice = ar;
          enter_step(0, 1'b0, ended);
        end
        OP_ACK, OP_NACK: begin
          ack_choice = (busy_op == OP_ACK);
          enter_step(3, 1'b0, ended);
        end
        default: enter_step(0, 1'b0, ended);
      endcase
    end
    levels.scl_out      = scl_lv;
    levels.sda_out      = sda_lv;
    levels.busy_res     = (busy_op != OP_IDLE);
    levels.done_res     = done;
    levels.read_data    = last_read;
    levels.ack_received = ack_lv;
    levels.rejected     = rej;
    bus_results_due.push_back(levels);
  endtask

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      error_count++;
    end
  endtask

  always @(posedge clk) begin
    result_t want;
    if (!rst_n) begin
      busy_op = OP_IDLE;
      step_ph = '0;
      bit_pos = '0;
      shifter = '0;
      wait_left = '0;
      half_period = HALF_PERIOD_RESET;
      last_read = '0;
      scl_lv = 1'b1;
      sda_lv = 1'b1;
      ack_lv = 1'b0;
      ack_choice = 1'b0;
      bus_results_due.delete();
      error_count = 0;
      open_count <= 0;
    end else begin
      if (cfg_valid && cfg_ready) half_period = cfg_data;
      if (in_valid && !in_stall) begin
        predict_bus_step(in_req_type, in_write_data, in_ack_after_read, in_sda_in);
      end
      if (out_valid && !out_stall) begin
        if (bus_results_due.size() == 0) begin
          $error("result arrived with no request outstanding");
          error_count++;
        end else begin
          want = bus_results_due.pop_front();
          check_field("scl_out", 8'(want.scl_out), 8'(out_scl_out));
          check_field("sda_out", 8'(want.sda_out), 8'(out_sda_out));
          check_field("busy_res", 8'(want.busy_res), 8'(out_busy_res));
          check_field("done_res", 8'(want.done_res), 8'(out_done_res));
          check_field("read_data", want.read_data, out_read_data);
          check_field("ack_received", 8'(want.ack_received), 8'(out_ack_received));
          check_field("rejected", 8'(want.rejected), 8'(out_rejected));
        end
      end
      open_count <= bus_results_due.size();
    end
  end

endmodule

/* tb/sv/testbench.sv */
// Top of the I2C master bit engine testbench: clock, reset, request and result traffic,
// half period writes and the final verdict.
// Depends on i2cmbe_pkg, i2c_master_bit_engine_core and i2c_bus_checker.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import i2cmbe_pkg::*;

  localparam int LONG_HOLD = 40;

  typedef enum {SDA_LOW, SDA_HIGH, SDA_RANDOM} sda_drive_t;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  logic [2:0] in_req_type;
  logic [7:0] in_write_data;
  logic       in_ack_after_read;
  logic       in_sda_in;
  logic       out_valid;
  logic       out_stall;
  logic       out_scl_out;
  logic       out_sda_out;
  logic       out_busy_res;
  logic       out_done_res;
  logic [7:0] out_read_data;
  logic       out_ack_received;
  logic       out_rejected;
  logic       cfg_valid;
  logic       cfg_ready;
  logic [7:0] cfg_data;
  int         fail_count;
  int         open_count;
  logic [7:0] cur_half;
  logic       bus_busy;
  logic       hold_off;
  logic       no_idle;

  i2c_master_bit_engine_core dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_req_type      (in_req_type),
    .in_write_data    (in_write_data),
    .in_ack_after_read(in_ack_after_read),
    .in_sda_in        (in_sda_in),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_scl_out      (out_scl_out),
    .out_sda_out      (out_sda_out),
    .out_busy_res     (out_busy_res),
    .out_done_res     (out_done_res),
    .out_read_data    (out_read_data),
    .out_ack_received (out_ack_received),
    .out_rejected     (out_rejected),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_data         (cfg_data)
  );

  i2c_bus_checker bus_check (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_req_type      (in_req_type),
    .in_write_data    (in_write_data),
    .in_ack_after_read(in_ack_after_read),
    .in_sda_in        (in_sda_in),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_scl_out      (out_scl_out),
    .out_sda_out      (out_sda_out),
    .out_busy_res     (out_busy_res),
    .out_done_res     (out_done_res),
    .out_read_data    (out_read_data),
    .out_ack_received (out_ack_received),
    .out_rejected     (out_rejected),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_data         (cfg_data),
    .error_count      (fail_count),
    .open_count       (open_count)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #800000;
    $display("testbench: done, errors");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst_n) bus_busy <= 1'b0;
    else if (out_valid && !out_stall) bus_busy <= out_busy_res;
  end

  initial begin : result_sink
    int burst;
    bit held;
    burst = 0;
    held = 1'b0;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off && !held) begin
        held = 1'b1;
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        out_stall <= 1'b0;
      end else if (no_idle) begin
        out_stall <= 1'b0;
      end else if (burst > 0) begin
        burst--;
      end else if ($urandom_range(0, 7) == 0) begin
        burst = $urandom_range(0, 3);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  function automatic int ticks_for(input op_t op);
    int h;
    h = (cur_half == 8'd0) ? 1 : cur_half;
    case (op)
      OP_STOP:  return h;
      OP_WRITE: return 24 * h;
      OP_READ:  return 19 * h;
      default:  return 3 * h;
    endcase
  endfunction

  task automatic send_request(input op_t rq, input logic [7:0] wd, input logic ar,
                              input logic sin);
    if (!no_idle && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req_type <= rq;
    in_write_data <= wd;
    in_ack_after_read <= ar;
    in_sda_in <= sin;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (open_count != 0) @(posedge clk);
  endtask

  // Waits for every result, then ticks on until the engine reports idle.
  task automatic settle_bus();
    drain_results();
    while (bus_busy) begin
      repeat (8) send_request(OP_IDLE, 8'($urandom), 1'($urandom_range(0, 1)),
                              1'($urandom_range(0, 1)));
      drain_results();
    end
  endtask

  task automatic set_half_period(input logic [7:0] ticks);
    cfg_valid <= 1'b1;
    cfg_data <= ticks;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cur_half = ticks;
  endtask

  task automatic run_command(input op_t op, input logic [7:0] wd, input logic ar,
                             input sda_drive_t drive);
    int n;
    n = ticks_for(op);
    send_request(op, wd, ar, 1'($urandom_range(0, 1)));
    repeat (n) begin
      send_request(OP_IDLE, ~wd, ~ar,
                   (drive == SDA_RANDOM) ? 1'($urandom_range(0, 1)) : (drive == SDA_HIGH));
    end
  endtask

  // Mostly complete commands with random content, some cut short, plus stray requests.
  task automatic random_traffic(input int n_items);
    int   sent;
    int   k;
    op_t  op;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(0, 9) == 0) begin
        send_request(op_t'($urandom_range(0, 7)), 8'($urandom), 1'($urandom_range(0, 1)),
                     1'($urandom_range(0, 1)));
        sent++;
      end else begin
        op = op_t'($urandom_range(1, 7));
        send_request(op, 8'($urandom), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        k = ticks_for(op);
        if ($urandom_range(0, 7) == 0) k = $urandom_range(0, k);
        else k += $urandom_range(0, 2);
        repeat (k) begin
          if ($urandom_range(0, 39) == 0) begin
            send_request(op_t'($urandom_range(1, 7)), 8'($urandom), 1'($urandom_range(0, 1)),
                         1'($urandom_range(0, 1)));
          end
          send_request(OP_IDLE, 8'($urandom), 1'($urandom_range(0, 1)),
                       1'($urandom_range(0, 1)));
        end
        sent += k + 1;
      end
    end
  endtask

  initial begin : stimulus
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_req_type = OP_IDLE;
    in_write_data = 8'h00;
    in_ack_after_read = 1'b0;
    in_sda_in = 1'b0;
    cfg_valid = 1'b0;
    cfg_data = 8'h00;
    hold_off = 1'b0;
    no_idle = 1'b0;
    cur_half = HALF_PERIOD_RESET;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Idle ticks, a stop at the reset half period and a start that arrives while busy.
    send_request(OP_IDLE, 8'hFF, 1'b1, 1'b0);
    send_request(OP_IDLE, 8'h00, 1'b0, 1'b1);
    send_request(OP_STOP, 8'hFF, 1'b1, 1'b1);
    send_request(OP_START, 8'h00, 1'b0, 1'b0);
    repeat (ticks_for(OP_STOP)) send_request(OP_IDLE, 8'h5A, 1'b0, 1'b1);
    settle_bus();

    // A zero half period behaves as one tick per phase.
    set_half_period(8'd0);
    run_command(OP_START, 8'h00, 1'b0, SDA_RANDOM);
    run_command(OP_WRITE, 8'hFF, 1'b0, SDA_RANDOM);
    run_command(OP_WAIT, 8'h00, 1'b1, SDA_LOW);
    run_command(OP_WRITE, 8'h00, 1'b1, SDA_RANDOM);
    run_command(OP_WAIT, 8'hFF, 1'b0, SDA_HIGH);
    run_command(OP_READ, 8'h00, 1'b1, SDA_HIGH);
    run_command(OP_READ, 8'hFF, 1'b0, SDA_LOW);
    run_command(OP_ACK, 8'hFF, 1'b0, SDA_RANDOM);
    run_command(OP_NACK, 8'h00, 1'b1, SDA_RANDOM);
    run_command(OP_STOP, 8'hA5, 1'b1, SDA_RANDOM);
    settle_bus();

    set_half_period(8'd1);
    random_traffic(80);
    settle_bus();

    hold_off <= 1'b1;
    set_half_period(8'd3);
    random_traffic(80);
    settle_bus();

    set_half_period(8'd2);
    random_traffic(80);
    settle_bus();

    set_half_period(8'($urandom_range(4, 6)));
    random_traffic(80);
    settle_bus();

    set_half_period(8'd0);
    random_traffic(80);
    settle_bus();

    set_half_period(8'd255);
    run_command(OP_STOP, 8'h3C, 1'b0, SDA_RANDOM);
    settle_bus();

    no_idle <= 1'b1;
    set_half_period(8'd2);
    random_traffic(80);
    drain_results();
    repeat (8) @(posedge clk);

    if (fail_count == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
